>>> hdl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types, codes and helpers of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package plt_pkg;

  // Input item: knot write or evaluate request
  typedef struct packed {
    logic               command;
    logic [3:0]         knot_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } plt_in_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] y_result;
    logic [1:0]         status;
  } plt_out_t;

  // Record handed from cell to cell during one pass along the knot row
  typedef struct packed {
    logic               valid;
    logic               pend;   // selected left knot waits for its right partner
    logic signed [31:0] xf;     // first knot
    logic signed [31:0] yf;
    logic signed [31:0] xl;     // last valid knot
    logic signed [31:0] xa;     // selected segment, left knot
    logic signed [31:0] ya;
    logic signed [31:0] xb;     // selected segment, right knot
    logic signed [31:0] yb;
  } plt_rec_t;

  // Search control broadcast to every cell while a pass runs
  typedef struct packed {
    logic signed [31:0] xq;     // search abscissa
    logic               all;    // select every cell up to the limit
  } plt_ctl_t;

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_KNOT_COUNT = 3'd0;
  localparam logic [2:0] CFG_LOW_MODE   = 3'd1;
  localparam logic [2:0] CFG_HIGH_MODE  = 3'd2;
  localparam logic [2:0] CFG_LOW_VALUE  = 3'd3;
  localparam logic [2:0] CFG_HIGH_VALUE = 3'd4;

  // Side modes
  localparam logic [1:0] MODE_CONST   = 2'd0;
  localparam logic [1:0] MODE_TANGENT = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;
  localparam logic [1:0] MODE_MIRROR  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_ZERO_WIDTH = 2'd2;

  // Divider geometry
  localparam int          DIV_STEPS   = 66;
  localparam int          DVD_W       = 66;
  localparam int          DSR_W       = 34;
  localparam int          QUO_W       = 42;
  localparam logic [41:0] QUOT_LIMIT  = 42'd1 << 40;

  // Magnitude of a 33-bit signed difference
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage

>>> hdl/plt_cell.sv
// ----------------------------------------------------------------------------
// plt_cell
// One knot of the table. Holds its (x, y) pair and updates the record that
// walks along the row, one cell per cycle.
// ----------------------------------------------------------------------------
module plt_cell #(
  parameter int IDX  = 0,
  parameter int CNTW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic signed [31:0] wr_x_i,
  input  logic signed [31:0] wr_y_i,
  input  plt_pkg::plt_ctl_t  ctl_i,
  input  logic [CNTW-1:0]    lim_i,
  input  logic [CNTW-1:0]    last_i,
  input  plt_pkg::plt_rec_t  rec_i,
  output plt_pkg::plt_rec_t  rec_o
);
  import plt_pkg::*;

  logic signed [31:0] kx_q, ky_q;
  logic               vld_q;
  plt_rec_t           rec_d, rec_q;
  logic               sel;

  // Store the knot
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      kx_q <= wr_x_i;
      ky_q <= wr_y_i;
    end
  end

  // Fill a pending right knot, then claim the segment if this knot qualifies
  always_comb begin
    rec_d = rec_i;
    sel   = (IDX == 0) || ((IDX <= int'(lim_i)) && (ctl_i.all || (kx_q <= ctl_i.xq)));
    if (rec_i.pend) begin
      rec_d.xb   = kx_q;
      rec_d.yb   = ky_q;
      rec_d.pend = 1'b0;
    end
    if (IDX == 0) begin
      rec_d.xf = kx_q;
      rec_d.yf = ky_q;
    end
    if (IDX == int'(last_i)) begin
      rec_d.xl = kx_q;
    end
    if (sel) begin
      rec_d.xa   = kx_q;
      rec_d.ya   = ky_q;
      rec_d.pend = 1'b1;
    end
  end

  // Hand the record on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_comb begin
    rec_o       = rec_q;
    rec_o.valid = vld_q;
  end

endmodule

>>> hdl/plt_div.sv
// ----------------------------------------------------------------------------
// plt_div
// Restoring divider, one quotient bit per cycle. The quotient saturates at
// its limit; the remainder is exact.
// ----------------------------------------------------------------------------
module plt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [plt_pkg::DVD_W-1:0]  dividend_i,
  input  logic [plt_pkg::DSR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [plt_pkg::QUO_W-1:0]  quot_o,
  output logic [plt_pkg::DSR_W-1:0]  rem_o
);
  import plt_pkg::*;

  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DSR_W:0]   rem_sh;
  logic [QUO_W-1:0] quo_sh;
  logic             fits;

  // One shift-subtract step
  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    fits   = rem_sh >= {1'b0, dsr_q};
    quo_sh = {quo_q[QUO_W-2:0], fits};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = CW'(DIV_STEPS);
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      rem_d = '0;
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
      dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
      rem_d  = fits ? DSR_W'(rem_sh - {1'b0, dsr_q}) : DSR_W'(rem_sh);
      quo_d  = (quo_sh > QUOT_LIMIT) ? QUOT_LIMIT : quo_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> hdl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Knot table as a row of cells, with a sequencer that runs passes along the
// row and a shared divider for wrapping and for the segment ratio.
// ----------------------------------------------------------------------------
// A knot write goes straight to the result state. An evaluate first runs one
// pass of the row to find the end knots, then for repeat and mirror modes a
// wrap division, then a second pass to pick the segment, a two-part multiply
// and the ratio division; the constant and single-knot paths end after the
// first pass. The bit-serial divider and the cell row set the length of an
// evaluate; one item is in work at a time, and the next is accepted while the
// previous result still waits at the output.
module piecewise_linear_interpolator #(
  parameter int MAX_KNOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  plt_pkg::plt_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output plt_pkg::plt_out_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i
);
  import plt_pkg::*;

  localparam int CNTW = $clog2(MAX_KNOTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PASSA = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_PASSB = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_MUL3  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Configuration
  logic [4:0]         knot_count_q;
  logic [1:0]         low_mode_q, high_mode_q;
  logic signed [31:0] low_val_q, high_val_q;
  logic [CNTW-1:0]    n_c;

  // Control
  logic [3:0] state_q, state_d;
  logic       launch_q, launch_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;

  // Payload
  logic signed [31:0] x_q, x_d;
  logic signed [31:0] xq_q, xq_d;
  logic               all_q, all_d;
  logic [CNTW-1:0]    lim_q, lim_d;
  logic signed [31:0] xf_q, xf_d, xl_q, xl_d;
  logic               low_q, low_d;
  logic [1:0]         mode_q, mode_d;
  logic [32:0]        range_q, range_d;
  logic signed [31:0] ya_q, ya_d;
  logic               neg_q, neg_d;
  logic [32:0]        ma_q, ma_d, mb_q, mb_d, mdx_q, mdx_d;
  logic [49:0]        pp_q, pp_d;
  logic [65:0]        prod_q, prod_d;
  logic signed [31:0] res_y_q, res_y_d;
  logic [1:0]         res_st_q, res_st_d;
  plt_out_t           out_q, out_d;

  // Row of cells
  plt_rec_t           rec [MAX_KNOTS+1];
  plt_rec_t           tail;
  plt_ctl_t           ctl;
  logic [CNTW-1:0]    last_c;

  // Divider
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DSR_W-1:0]   div_dsr;
  logic               div_done;
  logic [QUO_W-1:0]   div_quo;
  logic [DSR_W-1:0]   div_rem;

  // Decision terms
  logic signed [32:0] x33, xf33, xl33, rng33, dx, dy, tt;
  logic               in_span, low_c;
  logic [1:0]         mode_c;
  logic [34:0]        a35, r35, rem35;
  logic signed [34:0] xm35;
  logic [66:0]        prod_sum;
  logic signed [41:0] ysum;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= '0;
      low_mode_q   <= MODE_CONST;
      high_mode_q  <= MODE_CONST;
      low_val_q    <= '0;
      high_val_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KNOT_COUNT: knot_count_q <= cfg_wdata_i[4:0];
        CFG_LOW_MODE:   low_mode_q   <= cfg_wdata_i[1:0];
        CFG_HIGH_MODE:  high_mode_q  <= cfg_wdata_i[1:0];
        CFG_LOW_VALUE:  low_val_q    <= cfg_wdata_i;
        CFG_HIGH_VALUE: high_val_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clip count to the table size
  assign n_c    = (int'(knot_count_q) > MAX_KNOTS) ? CNTW'(MAX_KNOTS) : CNTW'(knot_count_q);
  assign last_c = n_c - CNTW'(1);

  // Build the cell row
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ctl.xq     = xq_q;
  assign ctl.all    = all_q;

  always_comb begin
    rec[0]       = '0;
    rec[0].valid = launch_q;
  end

  for (genvar gi = 0; gi < MAX_KNOTS; gi++) begin : g_cell
    logic wr_en;
    assign wr_en = in_acc && (in_item_i.command == CMD_WRITE) &&
                   (int'(in_item_i.knot_index) == gi);
    plt_cell #(
      .IDX  (gi),
      .CNTW (CNTW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_en_i (wr_en),
      .wr_x_i  (in_item_i.x_value),
      .wr_y_i  (in_item_i.y_value),
      .ctl_i   (ctl),
      .lim_i   (lim_q),
      .last_i  (last_c),
      .rec_i   (rec[gi]),
      .rec_o   (rec[gi+1])
    );
  end

  assign tail = rec[MAX_KNOTS];

  plt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  // Side and segment arithmetic
  always_comb begin
    x33      = 33'(x_q);
    xf33     = 33'(tail.xf);
    xl33     = 33'(tail.xl);
    rng33    = xl33 - xf33;
    in_span  = (x_q >= tail.xf) && (x_q <= tail.xl);
    low_c    = x_q < tail.xf;
    mode_c   = low_c ? low_mode_q : high_mode_q;
    dx       = 33'(tail.xb) - 33'(tail.xa);
    dy       = 33'(tail.yb) - 33'(tail.ya);
    tt       = 33'(xq_q) - 33'(tail.xa);
    rem35    = 35'(div_rem);
    a35      = 35'({range_q, 1'b0});
    r35      = (low_q && (div_rem != '0)) ? a35 - rem35 : rem35;
    if (mode_q == MODE_REPEAT) begin
      xm35 = low_q ? 35'(xl_q) - $signed(rem35) : 35'(xf_q) + $signed(rem35);
    end else begin
      xm35 = 35'(xf_q) + $signed((r35 <= 35'(range_q)) ? r35 : a35 - r35);
    end
    prod_sum = 67'(prod_q) + {pp_q, 17'b0};
    ysum     = neg_q ? 42'(ya_q) - $signed(div_quo) : 42'(ya_q) + $signed(div_quo);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    launch_d    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    x_d         = x_q;
    xq_d        = xq_q;
    all_d       = all_q;
    lim_d       = lim_q;
    xf_d        = xf_q;
    xl_d        = xl_q;
    low_d       = low_q;
    mode_d      = mode_q;
    range_d     = range_q;
    ya_d        = ya_q;
    neg_d       = neg_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    mdx_d       = mdx_q;
    pp_d        = pp_q;
    prod_d      = prod_q;
    res_y_d     = res_y_q;
    res_st_d    = res_st_q;
    div_start   = 1'b0;
    div_dvd     = DVD_W'(mag33(x33 - xf33));
    div_dsr     = (mode_c == MODE_REPEAT) ? DSR_W'(rng33) : DSR_W'({rng33, 1'b0});
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_y_d  = '0;
          res_st_d = ST_OK;
          if (in_item_i.command == CMD_WRITE) begin
            state_d = S_DONE;
          end else begin
            x_d      = in_item_i.x_value;
            launch_d = 1'b1;
            state_d  = S_PASSA;
          end
        end
      end
      S_PASSA: begin
        if (tail.valid) begin
          state_d = S_DONE;
          xq_d    = x_q;
          lim_d   = n_c - CNTW'(2);
          all_d   = 1'b0;
          if (n_c == '0) begin
            res_st_d = ST_EMPTY;
          end else if (in_span) begin
            if (n_c == CNTW'(1)) begin
              res_y_d = tail.yf;
            end else begin
              launch_d = 1'b1;
              state_d  = S_PASSB;
            end
          end else if (mode_c == MODE_CONST) begin
            res_y_d = low_c ? low_val_q : high_val_q;
          end else if (n_c == CNTW'(1)) begin
            res_y_d = tail.yf;
          end else if (mode_c == MODE_TANGENT) begin
            all_d    = 1'b1;
            lim_d    = low_c ? '0 : n_c - CNTW'(2);
            launch_d = 1'b1;
            state_d  = S_PASSB;
          end else if (rng33 <= 0) begin
            res_st_d = ST_ZERO_WIDTH;
          end else begin
            div_start = 1'b1;
            xf_d      = tail.xf;
            xl_d      = tail.xl;
            low_d     = low_c;
            mode_d    = mode_c;
            range_d   = 33'(rng33);
            state_d   = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (div_done) begin
          xq_d     = xm35[31:0];
          launch_d = 1'b1;
          state_d  = S_PASSB;
        end
      end
      S_PASSB: begin
        if (tail.valid) begin
          if (dx == 0) begin
            res_st_d = ST_ZERO_WIDTH;
            state_d  = S_DONE;
          end else begin
            ya_d    = tail.ya;
            neg_d   = ((dy < 0) != (tt < 0)) != (dx < 0);
            ma_d    = mag33(dy);
            mb_d    = mag33(tt);
            mdx_d   = mag33(dx);
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        pp_d    = ma_q * mb_q[16:0];
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod_d  = 66'(pp_q);
        pp_d    = 50'(ma_q * mb_q[32:17]);
        state_d = S_MUL3;
      end
      S_MUL3: begin
        div_start = 1'b1;
        div_dvd   = prod_sum[65:0];
        div_dsr   = DSR_W'(mdx_q);
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (ysum > 42'sd2147483647) begin
            res_y_d = 32'h7fff_ffff;
          end else if (ysum < -42'sd2147483648) begin
            res_y_d = 32'h8000_0000;
          end else begin
            res_y_d = ysum[31:0];
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.y_result   = res_y_q;
          out_d.status     = res_st_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    xq_q     <= xq_d;
    all_q    <= all_d;
    lim_q    <= lim_d;
    xf_q     <= xf_d;
    xl_q     <= xl_d;
    low_q    <= low_d;
    mode_q   <= mode_d;
    range_q  <= range_d;
    ya_q     <= ya_d;
    neg_q    <= neg_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    mdx_q    <= mdx_d;
    pp_q     <= pp_d;
    prod_q   <= prod_d;
    res_y_q  <= res_y_d;
    res_st_q <= res_st_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> dv/tb_piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// Self-checking bench: a queue-fed driver sends knot writes and evaluate
// items in random bursts, a local fixed-point predictor computes each result,
// and a monitor compares the results in order under random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator;
  import plt_pkg::*;

  localparam int NKNOT      = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 250;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  plt_in_t  in_item = '0;
  logic     out_stall = 1'b0;
  logic     cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic     in_stall_o, out_valid_o, cfg_ready_o;
  plt_out_t out_item_o;

  piecewise_linear_interpolator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: knot table and register copies
  logic signed [31:0] knot_x [NKNOT];
  logic signed [31:0] knot_y [NKNOT];
  logic [4:0]         knot_cnt = '0;
  logic [1:0]         low_mode = MODE_CONST, high_mode = MODE_CONST;
  logic signed [31:0] low_val = '0, high_val = '0;

  plt_in_t  item_q [$];
  plt_out_t result_q [$];
  int errors = 0, n_items = 0, n_results = 0, n_cfg = 0, n_sat = 0, n_zero = 0;
  int idle_cycles = 0;

  // Generator-side view of the knots already queued
  int gen_x [NKNOT];

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Interpolate on segment i; returns the status
  function automatic logic [1:0] segment_value(int i, longint x, output longint y);
    longint xa, xb, ya, yb, dx, dy, t, q;
    logic [127:0] prod;
    bit neg;
    xa = knot_x[i]; xb = knot_x[i+1];
    ya = knot_y[i]; yb = knot_y[i+1];
    dx = xb - xa; dy = yb - ya; t = x - xa;
    y = 0;
    if (dx == 0) return ST_ZERO_WIDTH;
    neg = ((dy < 0) != (t < 0)) != (dx < 0);
    prod = 128'(abs64(dy));
    prod = prod * 128'(abs64(t));
    prod = prod / 128'(abs64(dx));
    q = (prod > (128'd1 << 40)) ? (longint'(1) << 40) : longint'(prod);
    y = neg ? ya - q : ya + q;
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    return ST_OK;
  endfunction

  function automatic int segment_of(longint x, int n);
    int p;
    p = 0;
    for (int i = 1; i + 1 < n; i++)
      if (knot_x[i] <= x) p = i;
    return p;
  endfunction

  // Apply one item to the predictor and return its result
  function automatic plt_out_t predict_curve(plt_in_t it);
    plt_out_t r;
    longint x, y, xf, xl, rng, xm, a2, rr;
    int n;
    logic [1:0] md, st;
    bit low;
    r = '0;
    y = 0;
    st = ST_OK;
    if (it.command == CMD_WRITE) begin
      knot_x[it.knot_index] = it.x_value;
      knot_y[it.knot_index] = it.y_value;
      return r;
    end
    n = (knot_cnt > NKNOT) ? NKNOT : int'(knot_cnt);
    x = it.x_value;
    if (n == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    xf = knot_x[0];
    xl = knot_x[n-1];
    if (x >= xf && x <= xl) begin
      if (n == 1) y = knot_y[0];
      else st = segment_value(segment_of(x, n), x, y);
    end else begin
      low = x < xf;
      md = low ? low_mode : high_mode;
      if (md == MODE_CONST) y = low ? low_val : high_val;
      else if (n == 1) y = knot_y[0];
      else if (md == MODE_TANGENT) st = segment_value(low ? 0 : n - 2, x, y);
      else begin
        rng = xl - xf;
        if (rng <= 0) st = ST_ZERO_WIDTH;
        else begin
          if (md == MODE_REPEAT) xm = (x - xf) % rng + (low ? xl : xf);
          else begin
            a2 = rng * 2;
            rr = (x - xf) % a2;
            if (rr < 0) rr += a2;
            xm = xf + ((rr <= rng) ? rr : a2 - rr);
          end
          st = segment_value(segment_of(xm, n), xm, y);
        end
      end
    end
    if (st != ST_OK) y = 0;
    r.y_result = y[31:0];
    r.status = st;
    return r;
  endfunction

  // Driver: bursts of items separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        in_item <= item_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict each accepted item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall_o) begin
      result_q.push_back(predict_curve(in_item));
      n_items++;
    end
  end

  // Receiver stall pattern, with one long hold-off to back up the block
  int stall_mode = 0, mode_left = 0, hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (!hold_done && n_items >= 700) begin
        hold_done <= 1'b1;
        hold_left <= 600;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      if (hold_left > 0) out_stall <= 1'b1;
      else if (stall_mode == 0) out_stall <= 1'b0;
      else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    plt_out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: y_result=%0d status=%0d",
               out_item_o.y_result, out_item_o.status);
        errors++;
      end else begin
        exp_r = result_q.pop_front();
        n_results++;
        if (exp_r.y_result == 32'sh7fffffff || exp_r.y_result == 32'sh80000000) n_sat++;
        if (exp_r.status == ST_ZERO_WIDTH) n_zero++;
        if (out_item_o.y_result !== exp_r.y_result) begin
          $error("y_result mismatch: expected %0d, got %0d",
                 exp_r.y_result, out_item_o.y_result);
          errors++;
        end
        if (out_item_o.status !== exp_r.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_r.status, out_item_o.status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_KNOT_COUNT: knot_cnt = data[4:0];
      CFG_LOW_MODE:   low_mode = data[1:0];
      CFG_HIGH_MODE:  high_mode = data[1:0];
      CFG_LOW_VALUE:  low_val = data;
      CFG_HIGH_VALUE: high_val = data;
      default: ;
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int cnt, int lm, int hm, logic [31:0] lv, logic [31:0] hv);
    reg_write(CFG_KNOT_COUNT, cnt);
    reg_write(CFG_LOW_MODE, lm);
    reg_write(CFG_HIGH_MODE, hm);
    reg_write(CFG_LOW_VALUE, lv);
    reg_write(CFG_HIGH_VALUE, hv);
  endtask

  // Wait until every queued item is done and its result has arrived
  task automatic drain();
    wait (item_q.size() == 0 && !in_valid && result_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_write(int idx, int x, int y);
    plt_in_t it;
    it.command = CMD_WRITE;
    it.knot_index = 4'(idx);
    it.x_value = x;
    it.y_value = y;
    gen_x[idx] = x;
    item_q.push_back(it);
  endtask

  task automatic push_eval(int x);
    plt_in_t it;
    it.command = CMD_EVAL;
    it.knot_index = 4'($urandom());
    it.x_value = x;
    it.y_value = $urandom();
    item_q.push_back(it);
  endtask

  // Fill all slots: ascending, with duplicates or reversed now and then
  task automatic load_knots(int kind);
    int xs [NKNOT];
    int base, stp;
    stp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 1 << 27);
    base = $urandom_range(0, 1) ? -int'($urandom_range(0, 1 << 30)) : $urandom_range(0, 1 << 29);
    for (int i = 0; i < NKNOT; i++) begin
      if (kind == 3) xs[i] = $urandom();
      else xs[i] = base + i * stp + int'($urandom_range(0, stp / 2));
    end
    if (kind == 3) xs.sort();
    if (kind == 1) begin
      for (int i = 0; i < 3; i++) begin
        stp = $urandom_range(1, NKNOT - 1);
        xs[stp] = xs[stp-1];
      end
    end
    if (kind == 2) xs.reverse();
    for (int i = 0; i < NKNOT; i++) begin
      base = ($urandom_range(0, 4) == 0) ? int'($urandom()) : int'($urandom_range(0, 1 << 24)) - (1 << 23);
      push_write(i, xs[i], base);
    end
  endtask

  // Pick an evaluation point: on, near, inside or beyond the knots
  function automatic int pick_x(int n);
    longint lo, hi, span, v;
    int k;
    if (n < 1) n = 1;
    lo = gen_x[0];
    hi = gen_x[n-1];
    if (hi < lo) begin v = lo; lo = hi; hi = v; end
    span = hi - lo + 1;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 5))
      0: v = gen_x[k];
      1: v = longint'(gen_x[k]) + int'($urandom_range(0, 8)) - 4;
      2: v = lo + longint'($urandom()) % span;
      3: v = lo - 1 - longint'($urandom()) % (span * 3);
      4: v = hi + 1 + longint'($urandom()) % (span * 3);
      default: v = longint'(int'($urandom()));
    endcase
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return int'(v);
  endfunction

  initial begin
    int n, idx, steps, kind;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, full table, extremes and each mode
    push_eval(0);
    push_eval(32'h7fffffff);
    load_knots(0);
    drain();
    set_regs(31, MODE_CONST, MODE_CONST, 32'h80000000, 32'h7fffffff);
    push_eval(32'h80000000);
    push_eval(32'h7fffffff);
    push_eval(gen_x[5]);
    push_eval(gen_x[15]);
    drain();
    set_regs(16, MODE_TANGENT, MODE_TANGENT, 0, 0);
    push_eval(32'h80000000);
    push_eval(32'h7fffffff);
    push_eval(gen_x[0] - 1000);
    drain();
    set_regs(5, MODE_REPEAT, MODE_MIRROR, 0, 0);
    push_eval(gen_x[0] - 123457);
    push_eval(gen_x[4] + 98765);
    push_eval(32'h80000000);
    drain();
    set_regs(1, MODE_MIRROR, MODE_CONST, 32'h12345, 32'hfffe0000);
    push_eval(gen_x[0]);
    push_eval(gen_x[0] - 5);
    push_eval(gen_x[0] + 5);
    drain();
    load_knots(1);
    drain();
    set_regs(16, MODE_REPEAT, MODE_TANGENT, 0, 0);
    for (int i = 0; i < 4; i++) push_eval(pick_x(16));
    drain();
    load_knots(2);
    drain();
    set_regs(6, MODE_MIRROR, MODE_REPEAT, 0, 0);
    push_eval(gen_x[0] + 1);
    push_eval(gen_x[5] - 1);
    drain();

    // Random phases: new settings, optional reload, then mixed items
    while (n_items < 1950) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) load_knots(kind);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      drain();
      set_regs(n, $urandom_range(0, 3), $urandom_range(0, 3), $urandom(), $urandom());
      n = (n > NKNOT) ? NKNOT : n;
      steps = $urandom_range(40, 120);
      for (int s = 0; s < steps; s++) begin
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, NKNOT - 1);
          if (idx > 0 && idx < NKNOT - 1 && gen_x[idx-1] < gen_x[idx+1] &&
              $urandom_range(0, 3) != 0)
            push_write(idx, gen_x[idx-1] +
                       int'(longint'($urandom()) % (longint'(gen_x[idx+1]) - gen_x[idx-1] + 1)),
                       int'($urandom_range(0, 1 << 24)) - (1 << 23));
          else
            push_write(idx, $urandom(), $urandom());
        end else begin
          push_eval(pick_x(n));
        end
      end
    end
    drain();

    $display("Covered %0d items, %0d results, %0d register writes", n_items, n_results, n_cfg);
    $display("Saturated results: %0d, zero-width results: %0d", n_sat, n_zero);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
